### design/rcts_pkg.sv
package rcts_pkg;

  localparam int RELAY_W    = 4;
  localparam int IDX_W      = 2;
  localparam int TICK_W     = 32;
  localparam int RAND_W     = 32;
  localparam int TIMER_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int MOD_STEPS  = RAND_W / 8;
  localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_TEST_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_MASK      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL  = 2'd3;

  localparam logic [RELAY_W-1:0] RESET_CTRL_MASK     = 4'd15;
  localparam logic [TIMER_W-1:0] RESET_DEBOUNCE      = 16'd50;
  localparam logic [TIMER_W-1:0] RESET_STEP_INTERVAL = 16'd1000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BUTTON,
    S_MOD,
    S_STEP,
    S_DONE
  } rcts_state_t;

  typedef struct packed {
    logic capture;
    logic button_eval;
    logic mod_step;
    logic step_eval;
    logic load_out;
  } rcts_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic out_free;
  } rcts_status_t;

endpackage

### design/rcts_if.sv
interface rcts_tick_if import rcts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              button_down;
  logic [RAND_W-1:0] random_word;
  logic [RAND_W-1:0] random_word_alt;

  modport source(output valid, output button_down, output random_word,
                 output random_word_alt, input ready);
  modport sink(input valid, input button_down, input random_word,
               input random_word_alt, output ready);
endinterface

interface rcts_result_if import rcts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RELAY_W-1:0] relay_on_mask;
  logic               relay_changed;
  logic [IDX_W-1:0]   changed_index;
  logic               changed_to_on;
  logic               press_accepted;
  logic               phase_on;

  modport source(output valid, output relay_on_mask, output relay_changed,
                 output changed_index, output changed_to_on, output press_accepted,
                 output phase_on, input ready);
  modport sink(input valid, input relay_on_mask, input relay_changed,
               input changed_index, input changed_to_on, input press_accepted,
               input phase_on, output ready);
endinterface

### design/rcts_ctrl.sv
module rcts_ctrl import rcts_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         tick_valid,
  output logic         tick_ready,
  input  rcts_status_t sts,
  output rcts_cmd_t    cmd
);

  rcts_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (tick_valid) state_next = S_BUTTON;
      end
      S_BUTTON: state_next = S_MOD;
      S_MOD: begin
        if (sts.mod_done) state_next = S_STEP;
      end
      S_STEP: state_next = S_DONE;
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    tick_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        tick_ready  = 1'b1;
        cmd.capture = tick_valid;
      end
      S_BUTTON: cmd.button_eval = 1'b1;
      S_MOD:    cmd.mod_step = 1'b1;
      S_STEP:   cmd.step_eval = 1'b1;
      S_DONE:   cmd.load_out = sts.out_free;
      default: begin
        cmd        = '0;
        tick_ready = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && tick_valid) |=> (state == S_BUTTON))
    else $error("accepted item did not start evaluation");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over a pending result");
`endif

endmodule

### design/rcts_dp.sv
module rcts_dp import rcts_pkg::*; #(
  parameter int OUTPUT_COUNT = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  tick_button_down,
  input  logic [RAND_W-1:0]     tick_random_word,
  input  logic [RAND_W-1:0]     tick_random_word_alt,
  input  rcts_cmd_t             cmd,
  output rcts_status_t          sts,
  rcts_result_if.source         result
);

  localparam int RELAY_LIMIT = (OUTPUT_COUNT < RELAY_W) ? OUTPUT_COUNT : RELAY_W;
  localparam logic [RELAY_W-1:0] EXIST_MASK = RELAY_W'((1 << RELAY_LIMIT) - 1);

  logic               test_mode;
  logic [RELAY_W-1:0] ctrl_mask;
  logic [TIMER_W-1:0] debounce_ticks;
  logic [TIMER_W-1:0] step_interval;

  logic [TICK_W-1:0]  tick_count;
  logic [TICK_W-1:0]  last_button_tick;
  logic               button_state;
  logic [TICK_W-1:0]  last_step_tick;
  logic               turning_on;
  logic [RELAY_W-1:0] relay_state;

  logic               btn_level;
  logic [RAND_W-1:0]  rnd_a;
  logic [RAND_W-1:0]  rnd_b;
  logic [1:0]         mod_a;
  logic [1:0]         mod_b;
  logic [MOD_CNT_W-1:0] mod_count;

  logic               changed;
  logic [IDX_W-1:0]   cidx;
  logic               con;
  logic               press;
  logic               out_valid;

  logic [RELAY_W-1:0] drivable;
  logic [TICK_W-1:0]  btn_diff;
  logic [TICK_W-1:0]  step_diff;
  logic               btn_accept;
  logic               step_due;
  logic [IDX_W-1:0]   first_idx;
  logic               first_found;
  logic [RELAY_W-1:0] cand_a;
  logic [RELAY_W-1:0] cand_b;
  logic [IDX_W-1:0]   pick_a;
  logic [IDX_W-1:0]   pick_b;
  logic [1:0]         mod_a_next;
  logic [1:0]         mod_b_next;

  function automatic logic [1:0] mod3_add(input logic [1:0] acc, input logic [7:0] b);
    logic [3:0] s;
    logic [2:0] t;
    s = 4'(acc) + 4'(b[1:0]) + 4'(b[3:2]) + 4'(b[5:4]) + 4'(b[7:6]);
    t = 3'(s[3:2]) + 3'(s[1:0]);
    if (t >= 3'd6) t = t - 3'd6;
    else if (t >= 3'd3) t = t - 3'd3;
    return t[1:0];
  endfunction

  function automatic logic [IDX_W-1:0] pick_nth(input logic [RELAY_W-1:0] cand,
                                               input logic [1:0] m3,
                                               input logic [1:0] low);
    logic [2:0]       cnt;
    logic [1:0]       rem;
    logic [IDX_W-1:0] idx;
    logic             found;
    cnt   = '0;
    idx   = '0;
    found = 1'b0;
    for (int i = 0; i < RELAY_W; i++) cnt = cnt + 3'(cand[i]);
    unique case (cnt)
      3'd2:    rem = {1'b0, low[0]};
      3'd3:    rem = m3;
      3'd4:    rem = low;
      default: rem = 2'd0;
    endcase
    for (int i = 0; i < RELAY_W; i++) begin
      if (cand[i] && !found) begin
        if (rem == 2'd0) begin
          idx   = IDX_W'(i);
          found = 1'b1;
        end else begin
          rem = rem - 2'd1;
        end
      end
    end
    return idx;
  endfunction

  assign drivable   = ctrl_mask & EXIST_MASK;
  assign btn_diff   = tick_count - last_button_tick;
  assign step_diff  = tick_count - last_step_tick;
  assign btn_accept = (btn_level != button_state) &&
                      (btn_diff >= TICK_W'(debounce_ticks));
  assign step_due   = test_mode && (step_diff >= TICK_W'(step_interval));
  assign cand_a     = drivable & (turning_on ? ~relay_state : relay_state);
  assign cand_b     = drivable & (turning_on ? relay_state : ~relay_state);
  assign pick_a     = pick_nth(cand_a, mod_a, rnd_a[1:0]);
  assign pick_b     = pick_nth(cand_b, mod_b, rnd_b[1:0]);
  assign mod_a_next = mod3_add(mod_a, 8'(rnd_a >> {mod_count, 3'b000}));
  assign mod_b_next = mod3_add(mod_b, 8'(rnd_b >> {mod_count, 3'b000}));

  always_comb begin
    first_idx   = '0;
    first_found = 1'b0;
    for (int i = 0; i < RELAY_W; i++) begin
      if (drivable[i] && !first_found) begin
        first_idx   = IDX_W'(i);
        first_found = 1'b1;
      end
    end
  end

  assign sts.mod_done = (mod_count == MOD_CNT_W'(MOD_STEPS - 1));
  assign sts.out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      test_mode        <= 1'b0;
      ctrl_mask        <= RESET_CTRL_MASK;
      debounce_ticks   <= RESET_DEBOUNCE;
      step_interval    <= RESET_STEP_INTERVAL;
      tick_count       <= '0;
      last_button_tick <= '0;
      button_state     <= 1'b0;
      last_step_tick   <= '0;
      turning_on       <= 1'b1;
      relay_state      <= '0;
      mod_count        <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_TEST_MODE:      test_mode <= cfg_data[0];
          REG_CTRL_MASK:      ctrl_mask <= cfg_data[RELAY_W-1:0];
          REG_DEBOUNCE_TICKS: debounce_ticks <= cfg_data[TIMER_W-1:0];
          REG_STEP_INTERVAL:  step_interval <= cfg_data[TIMER_W-1:0];
          default: ;
        endcase
      end
      if (cmd.capture) begin
        mod_count <= '0;
      end
      if (cmd.mod_step) begin
        mod_count <= mod_count + MOD_CNT_W'(1);
      end
      if (cmd.button_eval && btn_accept) begin
        last_button_tick <= tick_count;
        button_state     <= btn_level;
        if (btn_level) begin
          if (test_mode) begin
            relay_state    <= relay_state & ~drivable;
            turning_on     <= 1'b1;
            last_step_tick <= tick_count;
          end else if (first_found) begin
            relay_state[first_idx] <= ~relay_state[first_idx];
          end
        end
      end
      if (cmd.step_eval) begin
        tick_count <= tick_count + TICK_W'(1);
        if (step_due) begin
          last_step_tick <= tick_count;
          if (|cand_a) begin
            relay_state[pick_a] <= turning_on;
          end else begin
            turning_on <= ~turning_on;
            if (|cand_b) relay_state[pick_b] <= ~turning_on;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      btn_level <= tick_button_down;
      rnd_a     <= tick_random_word;
      rnd_b     <= tick_random_word_alt;
      mod_a     <= 2'd0;
      mod_b     <= 2'd0;
      changed   <= 1'b0;
      cidx      <= '0;
      con       <= 1'b0;
      press     <= 1'b0;
    end
    if (cmd.mod_step) begin
      mod_a <= mod_a_next;
      mod_b <= mod_b_next;
    end
    if (cmd.button_eval && btn_accept && btn_level) begin
      press <= 1'b1;
      if (!test_mode && first_found) begin
        changed <= 1'b1;
        cidx    <= first_idx;
        con     <= ~relay_state[first_idx];
      end
    end
    if (cmd.step_eval && step_due) begin
      if (|cand_a) begin
        changed <= 1'b1;
        cidx    <= pick_a;
        con     <= turning_on;
      end else if (|cand_b) begin
        changed <= 1'b1;
        cidx    <= pick_b;
        con     <= ~turning_on;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.relay_on_mask  <= relay_state;
      result.relay_changed  <= changed;
      result.changed_index  <= cidx;
      result.changed_to_on  <= con;
      result.press_accepted <= press;
      result.phase_on       <= turning_on;
    end
  end

  assign result.valid = out_valid;

`ifndef SYNTHESIS
  a_no_phantom_relay: assert property (@(posedge clk) disable iff (rst)
    (relay_state & ~EXIST_MASK) == '0)
    else $error("relay beyond the output count switched");
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");
  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.relay_changed) |->
      (result.changed_index == '0 && !result.changed_to_on))
    else $error("change fields set without a change");
`endif

endmodule

### design/relay_click_test_sequencer_core.sv
// Relay click-test sequencer.
// tick: one item per millisecond tick, carrying the sampled button level and
//   two random words; taken at a rising edge with valid and ready high.
// result: one item per tick with the relay on mask, the single relay change
//   (if any), the press flag and the test phase.
// cfg_write / cfg_index / cfg_data: register writes, applied at the edge;
//   write only while no tick is in flight.
// Each tick's result is registered through these steps: capture at the accepting
//   edge, then button debounce, the byte-wise mod-3 unit on both random words,
//   the step evaluation and the output load. The next tick is accepted in the
//   cycle after the load, so one tick is finished before the next is taken.
// The result sits in an output register; a stalled receiver does not block the
//   next tick, but that tick waits in its last stage until the register frees.
// Reset (rst, synchronous) clears the tick counter and timers, releases the
//   button, turns all relays off, sets the phase to on and loads the register
//   defaults: normal mode, all relays drivable, debounce 50, step 1000.
module relay_click_test_sequencer_core import rcts_pkg::*; #(
  parameter int OUTPUT_COUNT = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rcts_tick_if.sink             tick,
  rcts_result_if.source         result
);

  rcts_cmd_t    cmd;
  rcts_status_t sts;

  rcts_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick.valid),
    .tick_ready (tick.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rcts_dp #(
    .OUTPUT_COUNT (OUTPUT_COUNT)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_write            (cfg_write),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .tick_button_down     (tick.button_down),
    .tick_random_word     (tick.random_word),
    .tick_random_word_alt (tick.random_word_alt),
    .cmd                  (cmd),
    .sts                  (sts),
    .result               (result)
  );

endmodule

### tb/tb_relay_click_test_sequencer_core.sv
`timescale 1ns / 1ps

module tb_relay_click_test_sequencer_core;
  import rcts_pkg::*;

  localparam int OUTPUTS        = 4;
  localparam int RELAY_LIMIT    = (OUTPUTS < RELAY_W) ? OUTPUTS : RELAY_W;
  localparam int PHASE_ITEMS    = 52;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic              button_down;
    logic [RAND_W-1:0] random_word;
    logic [RAND_W-1:0] random_word_alt;
  } tick_item_t;

  typedef struct packed {
    logic [RELAY_W-1:0] relay_on_mask;
    logic               relay_changed;
    logic [IDX_W-1:0]   changed_index;
    logic               changed_to_on;
    logic               press_accepted;
    logic               phase_on;
  } relay_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rcts_tick_if   tick_ch ();
  rcts_result_if result_ch ();

  relay_click_test_sequencer_core #(
    .OUTPUT_COUNT(OUTPUTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .tick     (tick_ch.sink),
    .result   (result_ch.source)
  );

  logic               mode_test   = 1'b0;
  logic [RELAY_W-1:0] drive_mask  = RESET_CTRL_MASK;
  logic [TIMER_W-1:0] debounce    = RESET_DEBOUNCE;
  logic [TIMER_W-1:0] step_period = RESET_STEP_INTERVAL;

  logic [TICK_W-1:0]  tick_now      = '0;
  logic [TICK_W-1:0]  last_edge     = '0;
  logic               button_level  = 1'b0;
  logic [TICK_W-1:0]  last_step     = '0;
  logic               phase_turn_on = 1'b1;
  logic [RELAY_W-1:0] relays_on     = '0;

  relay_result_t relay_results_due[$];
  int            error_count  = 0;
  int            results_seen = 0;
  bit            quiet        = 1'b0;
  logic          held_level   = 1'b0;
  int            held_left    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [RELAY_W-1:0] relays_off_target(input logic target);
    logic [RELAY_W-1:0] cand;
    cand = '0;
    for (int i = 0; i < RELAY_LIMIT; i++) begin
      if (drive_mask[i] && relays_on[i] != target) cand[i] = 1'b1;
    end
    return cand;
  endfunction

  function automatic int pick_relay(input logic [RELAY_W-1:0] cand,
                                    input logic [RAND_W-1:0] rnd);
    logic [RAND_W-1:0] count;
    logic [RAND_W-1:0] nth;
    count = '0;
    for (int i = 0; i < RELAY_W; i++) begin
      if (cand[i]) count++;
    end
    if (count == 0) return -1;
    nth = rnd % count;
    for (int i = 0; i < RELAY_W; i++) begin
      if (cand[i]) begin
        if (nth == 0) return i;
        nth--;
      end
    end
    return -1;
  endfunction

  function automatic relay_result_t advance_sequencer(input tick_item_t it);
    relay_result_t     r;
    logic [TICK_W-1:0] now;
    logic [TICK_W-1:0] since;
    int                idx;
    r        = '0;
    now      = tick_now;
    tick_now = now + 1;
    since    = now - last_edge;
    if (it.button_down != button_level && since >= {16'd0, debounce}) begin
      last_edge    = now;
      button_level = it.button_down;
      if (it.button_down) begin
        r.press_accepted = 1'b1;
        if (mode_test) begin
          relays_on     = relays_on & ~drive_mask;
          phase_turn_on = 1'b1;
          last_step     = now;
        end else begin
          for (int i = 0; i < RELAY_LIMIT; i++) begin
            if (drive_mask[i]) begin
              r.changed_to_on = !relays_on[i];
              relays_on[i]    = !relays_on[i];
              r.relay_changed = 1'b1;
              r.changed_index = IDX_W'(i);
              break;
            end
          end
        end
      end
    end
    since = now - last_step;
    if (mode_test && since >= {16'd0, step_period}) begin
      last_step = now;
      idx = pick_relay(relays_off_target(phase_turn_on), it.random_word);
      if (idx < 0) begin
        phase_turn_on = !phase_turn_on;
        idx = pick_relay(relays_off_target(phase_turn_on), it.random_word_alt);
      end
      if (idx >= 0) begin
        relays_on[idx]  = phase_turn_on;
        r.relay_changed = 1'b1;
        r.changed_index = IDX_W'(idx);
        r.changed_to_on = phase_turn_on;
      end
    end
    r.relay_on_mask = relays_on;
    r.phase_on      = phase_turn_on;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want_v);
    $display("mismatch at result %0d: %s got %0h expected %0h",
             results_seen, what, got, want_v);
    error_count++;
  endtask

  task automatic send_tick(input logic down, input logic [RAND_W-1:0] w1,
                           input logic [RAND_W-1:0] w2);
    tick_item_t it;
    it = '{button_down: down, random_word: w1, random_word_alt: w2};
    if (!quiet && $urandom_range(0, 99) < 27) begin
      tick_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 27);
    end
    tick_ch.valid           <= 1'b1;
    tick_ch.button_down     <= it.button_down;
    tick_ch.random_word     <= it.random_word;
    tick_ch.random_word_alt <= it.random_word_alt;
    do @(posedge clk); while (tick_ch.ready !== 1'b1);
    relay_results_due.push_back(advance_sequencer(it));
  endtask

  task automatic wait_idle();
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (relay_results_due.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_TEST_MODE:      mode_test   = value[0];
      REG_CTRL_MASK:      drive_mask  = value[RELAY_W-1:0];
      REG_DEBOUNCE_TICKS: debounce    = value[TIMER_W-1:0];
      REG_STEP_INTERVAL:  step_period = value[TIMER_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [RAND_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return RAND_W'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_tick(1'b1, '0, '0);
    send_tick(1'b0, '1, '1);
    send_tick(1'b1, $urandom, $urandom);
    send_tick(1'b0, $urandom, $urandom);
  endtask

  task automatic test_normal_toggle();
    wait_idle();
    write_reg(REG_TEST_MODE, 16'd0);
    write_reg(REG_CTRL_MASK, 16'hF);
    write_reg(REG_DEBOUNCE_TICKS, 16'd0);
    write_reg(REG_STEP_INTERVAL, 16'd0);
    repeat (2) begin
      send_tick(1'b1, $urandom, $urandom);
      send_tick(1'b0, $urandom, $urandom);
    end
    wait_idle();
    write_reg(REG_CTRL_MASK, 16'h8);
    send_tick(1'b1, $urandom, $urandom);
    send_tick(1'b0, $urandom, $urandom);
    wait_idle();
    write_reg(REG_CTRL_MASK, 16'h0);
    send_tick(1'b1, $urandom, $urandom);
    send_tick(1'b0, $urandom, $urandom);
  endtask

  task automatic test_debounce_limit();
    wait_idle();
    write_reg(REG_DEBOUNCE_TICKS, 16'hFFFF);
    send_tick(1'b1, $urandom, $urandom);
    send_tick(1'b0, $urandom, $urandom);
  endtask

  task automatic test_click_sequence();
    wait_idle();
    write_reg(REG_TEST_MODE, 16'd1);
    write_reg(REG_CTRL_MASK, 16'hF);
    write_reg(REG_DEBOUNCE_TICKS, 16'd0);
    write_reg(REG_STEP_INTERVAL, 16'd0);
    send_tick(1'b1, '0, '0);
    send_tick(1'b0, '1, '0);
    send_tick(1'b0, 32'd1, '0);
    send_tick(1'b0, '0, '0);
    send_tick(1'b0, '0, '1);
    send_tick(1'b1, 32'd2, 32'd3);
    send_tick(1'b0, $urandom, $urandom);
    wait_idle();
    write_reg(REG_CTRL_MASK, 16'h0);
    send_tick(1'b0, $urandom, $urandom);
    send_tick(1'b1, $urandom, $urandom);
    wait_idle();
    write_reg(REG_CTRL_MASK, 16'h5);
    write_reg(REG_STEP_INTERVAL, 16'hFFFF);
    send_tick(1'b0, $urandom, $urandom);
    send_tick(1'b1, $urandom, $urandom);
  endtask

  task automatic test_random_phase(input int phase);
    logic down;
    wait_idle();
    write_reg(REG_TEST_MODE, CFG_DATA_W'(phase % 2));
    write_reg(REG_CTRL_MASK, CFG_DATA_W'($urandom_range(0, 15)));
    write_reg(REG_DEBOUNCE_TICKS, CFG_DATA_W'($urandom_range(0, 8)));
    write_reg(REG_STEP_INTERVAL, $urandom_range(0, 1) ? CFG_DATA_W'($urandom_range(0, 3))
                                                       : CFG_DATA_W'($urandom_range(4, 12)));
    quiet = (phase == 3);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (phase == 6 && n == PHASE_ITEMS / 2) wait_idle();
      if ($urandom_range(0, 99) < 15) begin
        down = 1'($urandom_range(0, 1));
      end else begin
        if (held_left == 0) begin
          held_level = !held_level;
          held_left  = $urandom_range(1, int'(debounce) + 4);
        end
        held_left--;
        down = held_level;
      end
      send_tick(down, rand_word(), rand_word());
    end
    quiet = 1'b0;
  endtask

  initial begin
    relay_result_t want;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        if (relay_results_due.size() == 0) begin
          note_mismatch("result with nothing pending", 0, 0);
        end else begin
          want = relay_results_due.pop_front();
          if (result_ch.relay_on_mask !== want.relay_on_mask)
            note_mismatch("relay_on_mask", int'(result_ch.relay_on_mask),
                          int'(want.relay_on_mask));
          if (result_ch.relay_changed !== want.relay_changed)
            note_mismatch("relay_changed", int'(result_ch.relay_changed),
                          int'(want.relay_changed));
          if (result_ch.changed_index !== want.changed_index)
            note_mismatch("changed_index", int'(result_ch.changed_index),
                          int'(want.changed_index));
          if (result_ch.changed_to_on !== want.changed_to_on)
            note_mismatch("changed_to_on", int'(result_ch.changed_to_on),
                          int'(want.changed_to_on));
          if (result_ch.press_accepted !== want.press_accepted)
            note_mismatch("press_accepted", int'(result_ch.press_accepted),
                          int'(want.press_accepted));
          if (result_ch.phase_on !== want.phase_on)
            note_mismatch("phase_on", int'(result_ch.phase_on), int'(want.phase_on));
        end
        results_seen++;
      end
      result_ch.ready <= quiet || ($urandom_range(0, 99) >= 27);
    end
  end

  initial begin
    int stalled;
    stalled = 0;
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1) ||
          (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
        stalled = 0;
      else
        stalled++;
    end
    $display("watchdog expired with %0d results pending", relay_results_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst                     <= 1'b1;
    cfg_write               <= 1'b0;
    cfg_index               <= REG_TEST_MODE;
    cfg_data                <= '0;
    tick_ch.valid           <= 1'b0;
    tick_ch.button_down     <= 1'b0;
    tick_ch.random_word     <= '0;
    tick_ch.random_word_alt <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_normal_toggle();
    test_debounce_limit();
    test_click_sequence();
    for (int p = 0; p < 10; p++) test_random_phase(p);
    wait_idle();
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
